[rtl/srt_pkg.sv]
`timescale 1ns / 1ps
// Package for the stream ownership router: sizes, message kinds, error codes
// and the records that pass between the front, the queue and the back.
// Depends on nothing; every other file imports it.
package srt_pkg;

  localparam int STREAMS  = 16;
  localparam int CLIENTS  = 2;
  localparam int STREAM_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int KIND_W   = 2;
  localparam int CLIENT_W = 2;
  localparam int SID_W    = 8;
  localparam int CODE_W   = 8;
  localparam int DEST_W   = 2;
  localparam int ERR_W    = 3;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLIENT_CMD = 2'd0,
    KIND_CLIENT_PCM = 2'd1,
    KIND_DRIVER_RSP = 2'd2,
    KIND_DRIVER_PCM = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_TAKE_CODE    = 2'd0,
    REG_RELEASE_CODE = 2'd1,
    REG_OK_STATUS    = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_CLIENT = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_STREAM = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TAKE_FIRST = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BUSY       = 3'd4;
  localparam logic [ERR_W-1:0] ERR_NO_OWNER   = 3'd5;

  localparam logic [DEST_W-1:0]   DEST_DRIVER = 2'd0;
  localparam logic [CLIENT_W-1:0] OWNER_NONE  = 2'd0;

  typedef struct packed {
    logic [CODE_W-1:0] take_code;
    logic [CODE_W-1:0] release_code;
    logic [CODE_W-1:0] ok_status;
  } cfg_t;

  // One classified message as it waits in the queue.
  typedef struct packed {
    kind_e               kind;
    logic [CLIENT_W-1:0] client;
    logic [STREAM_W-1:0] stream;
    logic                is_take;
    logic                frees;
    logic [ERR_W-1:0]    pre_err;
  } entry_t;

endpackage

[rtl/srt_req_if.sv]
`timescale 1ns / 1ps
// Message channel into the router: valid, ready and the message fields.
// Depends on srt_pkg for the field widths.
interface srt_req_if;
  import srt_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0]   req_type;
  logic [CLIENT_W-1:0] client_id;
  logic [SID_W-1:0]    stream_num;
  logic [CODE_W-1:0]   cmd_code;
  logic [CODE_W-1:0]   cmd_status;

  modport source (output valid, req_type, client_id, stream_num, cmd_code, cmd_status,
                  input ready);
  modport sink   (input valid, req_type, client_id, stream_num, cmd_code, cmd_status,
                  output ready);
endinterface

[rtl/srt_rsp_if.sv]
`timescale 1ns / 1ps
// Routing decision channel out of the router: valid, ready and the result.
// Depends on srt_pkg for the field widths.
interface srt_rsp_if;
  import srt_pkg::*;

  logic              valid;
  logic              ready;
  logic              forward;
  logic [DEST_W-1:0] destination;
  logic [ERR_W-1:0]  error_code;

  modport source (output valid, forward, destination, error_code, input ready);
  modport sink   (input valid, forward, destination, error_code, output ready);
endinterface

[rtl/srt_front.sv]
`timescale 1ns / 1ps
// Front of the router: checks client and stream ids and decodes the command
// code against the configuration. Depends on srt_pkg and srt_req_if.
module srt_front (
  srt_req_if.sink        req_if,
  input  srt_pkg::cfg_t   cfg_i,
  input  logic            q_full_i,
  output logic            push_o,
  output srt_pkg::entry_t entry_o
);
  import srt_pkg::*;

  logic bad_client;
  logic bad_stream;
  logic is_take;
  logic is_release;

  assign req_if.ready = !q_full_i;
  assign push_o       = req_if.valid && !q_full_i;

  assign bad_client = !req_if.req_type[1] && (req_if.client_id >= CLIENT_W'(CLIENTS));
  assign bad_stream = ({1'b0, req_if.stream_num} >= (SID_W + 1)'(STREAMS));
  assign is_take    = (req_if.cmd_code == cfg_i.take_code);
  assign is_release = (req_if.cmd_code == cfg_i.release_code);

  always_comb begin
    entry_o.kind    = kind_e'(req_if.req_type);
    entry_o.client  = req_if.client_id;
    entry_o.stream  = req_if.stream_num[STREAM_W-1:0];
    entry_o.is_take = is_take;
    // A release, or a take the driver refused, frees the stream.
    entry_o.frees   = is_release || (is_take && (req_if.cmd_status != cfg_i.ok_status));
    priority if (bad_client) begin
      entry_o.pre_err = ERR_BAD_CLIENT;
    end else if (bad_stream) begin
      entry_o.pre_err = ERR_BAD_STREAM;
    end else begin
      entry_o.pre_err = ERR_NONE;
    end
  end
endmodule

[rtl/srt_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified messages between the front and the back.
// Depends on srt_pkg for the entry record and the depth.
module srt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  srt_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output srt_pkg::entry_t entry_o
);
  import srt_pkg::*;

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end
endmodule

[rtl/srt_back.sv]
`timescale 1ns / 1ps
// Back of the router: owner table lookup and update, and the result register.
// Depends on srt_pkg and srt_rsp_if.
module srt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  srt_pkg::entry_t entry_i,
  output logic            pop_o,
  srt_rsp_if.source       rsp_if
);
  import srt_pkg::*;

  logic [CLIENT_W-1:0] owner_q [STREAMS];
  logic                out_valid_q;
  logic                forward_q, forward_d;
  logic [DEST_W-1:0]   dest_q, dest_d;
  logic [ERR_W-1:0]    err_q, err_d;
  logic [CLIENT_W-1:0] owner;
  logic [CLIENT_W-1:0] self_tag;
  logic                wr_en;
  logic [CLIENT_W-1:0] wr_val;

  assign pop_o    = q_valid_i && (!out_valid_q || rsp_if.ready);
  assign owner    = owner_q[entry_i.stream];
  assign self_tag = entry_i.client + 1'b1;

  always_comb begin
    forward_d = 1'b0;
    dest_d    = DEST_DRIVER;
    err_d     = ERR_NONE;
    wr_en     = 1'b0;
    wr_val    = OWNER_NONE;
    priority if (entry_i.pre_err != ERR_NONE) begin
      err_d = entry_i.pre_err;
    end else if (!entry_i.kind[1]) begin
      // Client message.
      priority if (owner == OWNER_NONE) begin
        if (entry_i.kind == KIND_CLIENT_CMD && entry_i.is_take) begin
          forward_d = 1'b1;
          wr_en     = 1'b1;
          wr_val    = self_tag;
        end else begin
          err_d = ERR_TAKE_FIRST;
        end
      end else if (owner != self_tag) begin
        err_d = ERR_BUSY;
      end else begin
        forward_d = 1'b1;
      end
    end else begin
      // Driver message.
      if (owner == OWNER_NONE) begin
        err_d = ERR_NO_OWNER;
      end else begin
        forward_d = 1'b1;
        dest_d    = owner;
        wr_en     = (entry_i.kind == KIND_DRIVER_RSP) && entry_i.frees;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STREAMS; i++) begin
        owner_q[i] <= OWNER_NONE;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && wr_en) begin
        owner_q[entry_i.stream] <= wr_val;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (rsp_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      forward_q <= forward_d;
      dest_q    <= dest_d;
      err_q     <= err_d;
    end
  end

  assign rsp_if.valid       = out_valid_q;
  assign rsp_if.forward     = forward_q;
  assign rsp_if.destination = dest_q;
  assign rsp_if.error_code  = err_q;
endmodule

[rtl/stream_ownership_router.sv]
`timescale 1ns / 1ps
// Top level of the stream ownership router: APB register bank, front, queue
// and back. Depends on srt_pkg, srt_req_if, srt_rsp_if and the srt_ modules.
//
// Usage: each transaction on req_if is one message (client command, client
// PCM, driver command response or driver PCM) naming a stream and a code.
// For every message the router returns exactly one transaction on rsp_if
// that says whether to forward it, where to (0 the driver, else owner + 1)
// and an error code. An owner table of STREAMS entries records which client
// holds each stream; takes claim free streams, and releases or refused takes
// reported by the driver free them again.
// Flow: an accepted message is first written into the queue, and the owner
// table stage then loads the result register from the queue head.
// Throughput: one message per cycle while rsp_if.ready is high, set by the single
// owner table read and write that the back stage performs each cycle.
// Back-pressure: while rsp_if.ready is low the result register holds, the
// back stage stops, and the two-entry queue fills; req_if.ready then drops.
// Reset clears every table entry to unowned, empties the queue and the
// result register, and loads the register defaults (take 0, release 1, ok 0).
// Registers are written over APB at byte addresses 0, 4 and 8; they are to
// be changed only while no message is in flight.
module stream_ownership_router (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  srt_req_if.sink                    req_if,
  srt_rsp_if.source                  rsp_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [srt_pkg::APB_AW-1:0] paddr,
  input  logic [srt_pkg::APB_DW-1:0] pwdata,
  output logic [srt_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import srt_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;
  entry_t   front_entry;
  entry_t   head_entry;

  // The register bank answers every access without wait states.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.take_code    <= 8'd0;
      cfg_q.release_code <= 8'd1;
      cfg_q.ok_status    <= 8'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TAKE_CODE:    cfg_q.take_code    <= pwdata[CODE_W-1:0];
        REG_RELEASE_CODE: cfg_q.release_code <= pwdata[CODE_W-1:0];
        REG_OK_STATUS:    cfg_q.ok_status    <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TAKE_CODE:    prdata = {{(APB_DW - CODE_W){1'b0}}, cfg_q.take_code};
      REG_RELEASE_CODE: prdata = {{(APB_DW - CODE_W){1'b0}}, cfg_q.release_code};
      REG_OK_STATUS:    prdata = {{(APB_DW - CODE_W){1'b0}}, cfg_q.ok_status};
      default:          prdata = '0;
    endcase
  end

  // Front classifies each message as it is accepted.
  srt_front u_front (
    .req_if   (req_if),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (front_entry)
  );

  // The queue lets the front keep accepting while the receiver stalls, until it is full.
  srt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  // The back owns the table and is the only place it is read or written,
  // so messages see ownership changes in arrival order.
  srt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .entry_i   (head_entry),
    .pop_o     (pop),
    .rsp_if    (rsp_if)
  );

`ifndef SYNTHESIS
  // A stalled result must not be overwritten by the back stage.
  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_if.valid && !rsp_if.ready) |-> !pop)
    else $error("back stage advanced while the result was stalled");

  // Every error result is a dropped message.
  a_err_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_if.valid && rsp_if.error_code != ERR_NONE) |-> !rsp_if.forward)
    else $error("message with an error was forwarded");

  // An accepted message is waiting in the queue on the next cycle.
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_if.valid && req_if.ready) |=> q_valid)
    else $error("accepted message missing from the queue");
`endif

endmodule
